// ----- hdl/apc_pkg.sv -----
// Shared types and constants of the asset price conversion block.
`timescale 1ns / 1ps
package apc_pkg;

  localparam int SUPPLY_BITS = 63;
  localparam logic [SUPPLY_BITS-1:0] SUPPLY_RESET = 63'd1000000000000000;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_MATCH  = 2'd1;
  localparam logic [1:0] ST_ZERO_DIV  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [1:0] status;
  } ctl_t;

endpackage

// ----- hdl/apc_front.sv -----
// Side selection, split multiplier, rounding add and range check ahead of the divider.
`timescale 1ns / 1ps
module apc_front import apc_pkg::*; #(
  parameter int AB = 63,
  parameter int IB = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          command,
  input  logic [AB-1:0] amount,
  input  logic [IB-1:0] amount_asset,
  input  logic [AB-1:0] base_amount,
  input  logic [IB-1:0] base_asset,
  input  logic [AB-1:0] quote_amount,
  input  logic [IB-1:0] quote_asset,
  output ctl_t          out_ctl,
  output logic [AB-1:0] out_rem,
  output logic [AB-1:0] out_lq,
  output logic [AB-1:0] out_div,
  output logic [IB-1:0] out_target
);

  localparam int H = (AB + 1) / 2;
  localparam int L = AB - H;
  localparam int W = 2 * AB;

  ctl_t          ctl1, ctl2, ctl3;
  logic          up1, up2, up3;
  logic [AB-1:0] amt1, mult1, div1, div2, div3;
  logic [IB-1:0] tgt1, tgt2, tgt3;
  logic [2*H-1:0] p00;
  logic [H+L-1:0] p01, p10;
  logic [2*L-1:0] p11;
  logic [W-1:0]  prod3;

  ctl_t          ctl1_next;
  logic [AB-1:0] mult1_next, div1_next;
  logic [IB-1:0] tgt1_next;
  logic [H+L:0]  mid;
  logic [W-1:0]  mid_ext, round_ext, prod_next;
  logic          ovf;

  always_comb begin
    ctl1_next.valid = in_valid;
    if (amount_asset == base_asset) begin
      mult1_next = quote_amount;
      div1_next = base_amount;
      tgt1_next = quote_asset;
      ctl1_next.status = (base_amount == '0) ? ST_ZERO_DIV : ST_OK;
    end else if (amount_asset == quote_asset) begin
      mult1_next = base_amount;
      div1_next = quote_amount;
      tgt1_next = base_asset;
      ctl1_next.status = (quote_amount == '0) ? ST_ZERO_DIV : ST_OK;
    end else begin
      mult1_next = base_amount;
      div1_next = quote_amount;
      tgt1_next = '0;
      ctl1_next.status = ST_NO_MATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
    end else begin
      ctl1.valid <= ctl1_next.valid;
    end
    ctl1.status <= ctl1_next.status;
    up1 <= command;
    amt1 <= amount;
    mult1 <= mult1_next;
    div1 <= div1_next;
    tgt1 <= tgt1_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2.valid <= 1'b0;
    end else begin
      ctl2.valid <= ctl1.valid;
    end
    ctl2.status <= ctl1.status;
    up2 <= up1;
    div2 <= div1;
    tgt2 <= tgt1;
    p00 <= amt1[H-1:0] * mult1[H-1:0];
    p01 <= amt1[H-1:0] * mult1[AB-1:H];
    p10 <= amt1[AB-1:H] * mult1[H-1:0];
    p11 <= amt1[AB-1:H] * mult1[AB-1:H];
  end

  always_comb begin
    mid = {1'b0, p01} + {1'b0, p10};
    mid_ext = {{(W-H-L-1){1'b0}}, mid} << H;
    round_ext = up2 ? {{AB{1'b0}}, div2 - {{(AB-1){1'b0}}, 1'b1}} : '0;
    prod_next = {p11, p00} + mid_ext + round_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3.valid <= 1'b0;
    end else begin
      ctl3.valid <= ctl2.valid;
    end
    ctl3.status <= ctl2.status;
    up3 <= up2;
    div3 <= div2;
    tgt3 <= tgt2;
    prod3 <= prod_next;
  end

  assign ovf = prod3[W-1:AB] >= div3;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else begin
      out_ctl.valid <= ctl3.valid;
    end
    out_ctl.status <= (ctl3.status == ST_OK && ovf) ? ST_OVERFLOW : ctl3.status;
    out_rem <= prod3[W-1:AB];
    out_lq <= prod3[AB-1:0];
    out_div <= div3;
    out_target <= tgt3;
  end

  logic unused_up;
  assign unused_up = up3;

endmodule

// ----- hdl/apc_div_cell.sv -----
// One restoring division step: brings down one dividend bit and forms one quotient bit.
`timescale 1ns / 1ps
module apc_div_cell import apc_pkg::*; #(
  parameter int AB = 63,
  parameter int IB = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  ctl_t          in_ctl,
  input  logic [AB-1:0] in_rem,
  input  logic [AB-1:0] in_lq,
  input  logic [AB-1:0] in_div,
  input  logic [IB-1:0] in_target,
  output ctl_t          out_ctl,
  output logic [AB-1:0] out_rem,
  output logic [AB-1:0] out_lq,
  output logic [AB-1:0] out_div,
  output logic [IB-1:0] out_target
);

  logic [AB:0] trial;
  logic        ge;
  logic [AB:0] diff;

  always_comb begin
    trial = {in_rem, in_lq[AB-1]};
    ge = trial >= {1'b0, in_div};
    diff = trial - {1'b0, in_div};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else begin
      out_ctl.valid <= in_ctl.valid;
    end
    out_ctl.status <= in_ctl.status;
    out_rem <= ge ? diff[AB-1:0] : trial[AB-1:0];
    out_lq <= {in_lq[AB-2:0], ge};
    out_div <= in_div;
    out_target <= in_target;
  end

endmodule

// ----- hdl/asset_price_conversion.sv -----
// Top level of the asset price conversion pipeline.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------
//  config    | max_supply_we        | max_supply_wdata
//  input     | start, busy          | command, amount, amount_asset, base/quote
//  result    | done                 | result_amount, result_asset, status
//
// One item enters per cycle; busy stays low.
// The pipeline has four front stages, one division cell per quotient bit,
// and the output register.
// Reset clears all valid flags and loads the supply limit.
// Results cannot be stalled; each is shown for one cycle under done.
`timescale 1ns / 1ps
module asset_price_conversion import apc_pkg::*; #(
  parameter int AMOUNT_BITS = 63,
  parameter int ASSET_ID_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     max_supply_we,
  input  logic [SUPPLY_BITS-1:0]   max_supply_wdata,
  input  logic                     start,
  output logic                     busy,
  input  logic                     command,
  input  logic [AMOUNT_BITS-1:0]   amount,
  input  logic [ASSET_ID_BITS-1:0] amount_asset,
  input  logic [AMOUNT_BITS-1:0]   base_amount,
  input  logic [ASSET_ID_BITS-1:0] base_asset,
  input  logic [AMOUNT_BITS-1:0]   quote_amount,
  input  logic [ASSET_ID_BITS-1:0] quote_asset,
  output logic                     done,
  output logic [AMOUNT_BITS-1:0]   result_amount,
  output logic [ASSET_ID_BITS-1:0] result_asset,
  output logic [1:0]               status
);

  localparam int AB = AMOUNT_BITS;
  localparam int IB = ASSET_ID_BITS;
  localparam int CW = (AB > SUPPLY_BITS) ? AB : SUPPLY_BITS;

  logic [SUPPLY_BITS-1:0] max_supply;

  ctl_t          ctl [AB+1];
  logic [AB-1:0] rem [AB+1];
  logic [AB-1:0] lq  [AB+1];
  logic [AB-1:0] dv  [AB+1];
  logic [IB-1:0] tgt [AB+1];

  logic          above;
  logic [1:0]    status_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_supply <= SUPPLY_RESET;
    end else if (max_supply_we) begin
      max_supply <= max_supply_wdata;
    end
  end

  apc_front #(.AB(AB), .IB(IB)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (start & ~busy),
    .command      (command),
    .amount       (amount),
    .amount_asset (amount_asset),
    .base_amount  (base_amount),
    .base_asset   (base_asset),
    .quote_amount (quote_amount),
    .quote_asset  (quote_asset),
    .out_ctl      (ctl[0]),
    .out_rem      (rem[0]),
    .out_lq       (lq[0]),
    .out_div      (dv[0]),
    .out_target   (tgt[0])
  );

  for (genvar i = 0; i < AB; i++) begin : g_cell
    apc_div_cell #(.AB(AB), .IB(IB)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .in_ctl     (ctl[i]),
      .in_rem     (rem[i]),
      .in_lq      (lq[i]),
      .in_div     (dv[i]),
      .in_target  (tgt[i]),
      .out_ctl    (ctl[i+1]),
      .out_rem    (rem[i+1]),
      .out_lq     (lq[i+1]),
      .out_div    (dv[i+1]),
      .out_target (tgt[i+1])
    );
  end

  always_comb begin
    above = CW'(lq[AB]) > CW'(max_supply);
    if (ctl[AB].status == ST_OK && above) begin
      status_next = ST_OVERFLOW;
    end else begin
      status_next = ctl[AB].status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl[AB].valid;
    end
    status <= status_next;
    result_asset <= tgt[AB];
    result_amount <= (status_next == ST_OK) ? lq[AB] : '0;
  end

  logic unused_tail;
  assign unused_tail = ^{rem[AB], dv[AB]};

endmodule

// ----- hdl/apc_checker.sv -----
// Port-level checks of the asset price conversion block and their binding.
`timescale 1ns / 1ps
module apc_checker import apc_pkg::*; #(
  parameter int AMOUNT_BITS = 63,
  parameter int ASSET_ID_BITS = 32
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     busy,
  input logic                     done,
  input logic [AMOUNT_BITS-1:0]   result_amount,
  input logic [ASSET_ID_BITS-1:0] result_asset,
  input logic [1:0]               status
);

  a_no_busy: assert property (@(posedge clk) !busy)
    else $error("The block refused an item.");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("A result appeared right after reset.");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> result_amount == '0)
    else $error("A flagged result carries a nonzero amount.");

  a_nomatch_asset: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_NO_MATCH) |-> result_asset == '0)
    else $error("An unmatched item carries an asset.");

endmodule

bind asset_price_conversion apc_checker #(
  .AMOUNT_BITS   (AMOUNT_BITS),
  .ASSET_ID_BITS (ASSET_ID_BITS)
) u_apc_checker (
  .clk           (clk),
  .rst           (rst),
  .busy          (busy),
  .done          (done),
  .result_amount (result_amount),
  .result_asset  (result_asset),
  .status        (status)
);

// ----- tb/sv/asset_price_conversion_test.sv -----
// Self-checking testbench of the asset price conversion block.
`timescale 1ns / 1ps
module asset_price_conversion_test;
  import apc_pkg::*;

  localparam int AMOUNT_BITS = 63;
  localparam int ASSET_ID_BITS = 32;
  localparam int LATENCY = AMOUNT_BITS + 5;
  localparam logic [62:0] AMT_MAX = {63{1'b1}};
  localparam logic [31:0] ID_MAX = 32'hffff_ffff;

  typedef struct packed {
    logic [AMOUNT_BITS-1:0] amount;
    logic [ASSET_ID_BITS-1:0] asset;
    logic [1:0] status;
  } conversion_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic max_supply_we = 1'b0;
  logic [SUPPLY_BITS-1:0] max_supply_wdata = '0;
  logic start = 1'b0;
  logic busy;
  logic command = 1'b0;
  logic [AMOUNT_BITS-1:0] amount = '0;
  logic [ASSET_ID_BITS-1:0] amount_asset = '0;
  logic [AMOUNT_BITS-1:0] base_amount = '0;
  logic [ASSET_ID_BITS-1:0] base_asset = '0;
  logic [AMOUNT_BITS-1:0] quote_amount = '0;
  logic [ASSET_ID_BITS-1:0] quote_asset = '0;
  logic done;
  logic [AMOUNT_BITS-1:0] result_amount;
  logic [ASSET_ID_BITS-1:0] result_asset;
  logic [1:0] status;

  logic [SUPPLY_BITS-1:0] supply_limit;
  conversion_t expected_conversions[$];
  int error_count = 0;
  int burst_left = 0;

  asset_price_conversion #(.AMOUNT_BITS(AMOUNT_BITS), .ASSET_ID_BITS(ASSET_ID_BITS)) dut (
    .clk(clk), .rst(rst), .max_supply_we(max_supply_we),
    .max_supply_wdata(max_supply_wdata), .start(start), .busy(busy),
    .command(command), .amount(amount), .amount_asset(amount_asset),
    .base_amount(base_amount), .base_asset(base_asset),
    .quote_amount(quote_amount), .quote_asset(quote_asset), .done(done),
    .result_amount(result_amount), .result_asset(result_asset), .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic conversion_t convert(input logic up, input logic [62:0] amt,
      input logic [31:0] a_id, input logic [62:0] b_amt, input logic [31:0] b_id,
      input logic [62:0] q_amt, input logic [31:0] q_id);
    conversion_t r;
    logic [62:0] mult;
    logic [62:0] divisor;
    logic [127:0] product;
    logic [127:0] quotient;
    r = '0;
    if (a_id == b_id) begin
      mult = q_amt;
      divisor = b_amt;
      r.asset = q_id;
    end else if (a_id == q_id) begin
      mult = b_amt;
      divisor = q_amt;
      r.asset = b_id;
    end else begin
      r.status = ST_NO_MATCH;
      return r;
    end
    if (divisor == '0) begin
      r.status = ST_ZERO_DIV;
      return r;
    end
    product = 128'(amt) * 128'(mult);
    if (up) product = product + 128'(divisor) - 128'd1;
    quotient = product / 128'(divisor);
    if (quotient > 128'(supply_limit) || quotient > 128'(AMT_MAX)) r.status = ST_OVERFLOW;
    else r.amount = quotient[62:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
      input logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  always @(posedge clk) begin
    conversion_t want;
    if (!rst && done) begin
      if (expected_conversions.size() == 0) begin
        report_mismatch("unexpected result", 64'(result_amount), 64'd0);
      end else begin
        want = expected_conversions.pop_front();
        if (result_amount !== want.amount)
          report_mismatch("result_amount", 64'(result_amount), 64'(want.amount));
        if (result_asset !== want.asset)
          report_mismatch("result_asset", 64'(result_asset), 64'(want.asset));
        if (status !== want.status)
          report_mismatch("status", 64'(status), 64'(want.status));
      end
    end
  end

  task automatic send_item(input logic up, input logic [62:0] amt,
      input logic [31:0] a_id, input logic [62:0] b_amt, input logic [31:0] b_id,
      input logic [62:0] q_amt, input logic [31:0] q_id);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 8)) : 0;
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    start <= 1'b1;
    command <= up;
    amount <= amt;
    amount_asset <= a_id;
    base_amount <= b_amt;
    base_asset <= b_id;
    quote_amount <= q_amt;
    quote_asset <= q_id;
    do @(posedge clk); while (busy);
    expected_conversions.push_back(convert(up, amt, a_id, b_amt, b_id, q_amt, q_id));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_conversions.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_supply_limit(input logic [62:0] value);
    drain_results();
    max_supply_we <= 1'b1;
    max_supply_wdata <= value;
    @(posedge clk);
    max_supply_we <= 1'b0;
    supply_limit = value;
  endtask

  function automatic logic [62:0] random_amount();
    logic [62:0] v;
    v = 63'({$urandom, $urandom});
    case ($urandom_range(0, 4))
      0: v = v >> $urandom_range(0, 62);
      1: v = 63'($urandom_range(0, 1000));
      2: v = AMT_MAX - 63'($urandom_range(0, 3));
      default: v = v >> $urandom_range(20, 50);
    endcase
    return v;
  endfunction

  task automatic test_directed();
    send_item(1'b0, 63'd10, 32'd1, 63'd3, 32'd1, 63'd7, 32'd2);
    send_item(1'b1, 63'd10, 32'd1, 63'd3, 32'd1, 63'd7, 32'd2);
    send_item(1'b0, 63'd10, 32'd2, 63'd3, 32'd1, 63'd7, 32'd2);
    send_item(1'b1, 63'd10, 32'd2, 63'd3, 32'd1, 63'd7, 32'd2);
    send_item(1'b0, 63'd5, 32'd9, 63'd4, 32'd9, 63'd8, 32'd9);
    send_item(1'b0, 63'd5, 32'd3, 63'd4, 32'd1, 63'd8, 32'd2);
    send_item(1'b0, 63'd5, 32'd1, 63'd0, 32'd1, 63'd8, 32'd2);
    send_item(1'b1, 63'd5, 32'd2, 63'd4, 32'd1, 63'd0, 32'd2);
    send_item(1'b0, AMT_MAX, ID_MAX, AMT_MAX, ID_MAX, AMT_MAX, 32'd0);
    send_item(1'b1, AMT_MAX, ID_MAX, 63'd1, ID_MAX, AMT_MAX, 32'd0);
    send_item(1'b0, 63'd0, 32'd0, AMT_MAX, 32'd0, AMT_MAX, ID_MAX);
    send_item(1'b1, 63'd0, 32'd0, 63'd1, 32'd0, 63'd1, ID_MAX);
    send_item(1'b0, AMT_MAX, 32'd7, AMT_MAX, 32'd7, 63'd1, 32'd8);
    send_item(1'b1, AMT_MAX, 32'd7, AMT_MAX - 63'd1, 32'd7, 63'd1, 32'd8);
    send_item(1'b0, 63'd1000000000000000, 32'd1, 63'd1, 32'd1, 63'd1, 32'd2);
    send_item(1'b0, 63'd1000000000000001, 32'd1, 63'd1, 32'd1, 63'd1, 32'd2);
  endtask

  task automatic test_limits();
    set_supply_limit(63'd0);
    send_item(1'b0, 63'd0, 32'd1, 63'd5, 32'd1, 63'd5, 32'd2);
    send_item(1'b1, 63'd1, 32'd1, 63'd5, 32'd1, 63'd5, 32'd2);
    send_item(1'b0, 63'd1, 32'd1, 63'd5, 32'd1, 63'd5, 32'd2);
    set_supply_limit(AMT_MAX);
    send_item(1'b0, AMT_MAX, 32'd1, 63'd5, 32'd1, 63'd5, 32'd2);
    send_item(1'b1, AMT_MAX, 32'd1, 63'd2, 32'd1, 63'd3, 32'd2);
  endtask

  task automatic test_random(input int count);
    logic [31:0] ids[3];
    logic [31:0] a_id;
    for (int i = 0; i < count; i++) begin
      for (int k = 0; k < 3; k++)
        ids[k] = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 3));
      case ($urandom_range(0, 9)) inside
        0: a_id = $urandom;
        [1:4]: a_id = ids[1];
        default: a_id = ids[2];
      endcase
      send_item(1'($urandom_range(0, 1)), random_amount(), a_id,
        ($urandom_range(0, 15) == 0) ? 63'd0 : random_amount(), ids[1],
        ($urandom_range(0, 15) == 0) ? 63'd0 : random_amount(), ids[2]);
      if (i == count / 2) drain_results();
    end
  endtask

  initial begin
    supply_limit = SUPPLY_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_limits();
    test_random(600);
    set_supply_limit(63'd1 << $urandom_range(20, 50));
    test_random(600);
    set_supply_limit(SUPPLY_RESET);
    test_random(700);
    drain_results();
    if (error_count == 0) $display("[asset_price_conversion] OK");
    else $display("[asset_price_conversion] ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("[asset_price_conversion] ERROR");
    $finish;
  end
endmodule

// ----- asset_price_conversion.f -----
hdl/apc_pkg.sv
hdl/apc_front.sv
hdl/apc_div_cell.sv
hdl/asset_price_conversion.sv
hdl/apc_checker.sv
tb/sv/asset_price_conversion_test.sv
